FILE: design/rtpf_pkg.sv
// Shared widths, control word layout, saturation helpers and the sequencer program.
package rtpf_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int STATE_BITS     = 40;
    localparam int COEF_W         = 24;
    localparam int MIX_W          = 21;

    // Magnitude multiply split: the state operand is cut into a low and a high piece.
    localparam int LO_W     = COEF_FRAC_BITS;
    localparam int HI_W     = STATE_BITS - LO_W;
    localparam int PLO_W    = COEF_W + LO_W;
    localparam int PHI_W    = COEF_W + HI_W;
    localparam int QMAG_W   = PHI_W + 1;
    localparam int TERM_W   = QMAG_W + 1;
    localparam int ACC_W    = TERM_W + 2;
    localparam int CSEL_W   = COEF_W + 1;

    localparam longint FREQ_LIMIT_L =
        ((64'd130899581 << COEF_FRAC_BITS) + 64'd50000000) / 64'd100000000;
    localparam logic signed [COEF_W-1:0] FREQ_LIMIT = COEF_W'(FREQ_LIMIT_L);
    localparam logic [MIX_W-1:0] MIX_RESET = MIX_W'(64'd1 << COEF_FRAC_BITS);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_PASS_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_COEF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP_COEF_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_COEF_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP_COEF_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_COEF_B   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_RATIO_A   = 3'd6;

    localparam int PC_W = 6;
    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t PC_ONE_PASS = 6'd22;

    typedef enum logic [2:0] {
        C_FREQ, C_DAMP_A, C_GAIN_A, C_DAMP_B, C_GAIN_B, C_MIX
    } coef_sel_t;

    typedef enum logic [2:0] {
        S_X, S_BAND_A, S_LOW_A, S_BAND_B, S_LOW_B
    } opnd_sel_t;

    typedef enum logic [2:0] {
        B_HOLD, B_ZERO, B_ACC, B_LOW_A, B_LOW_B, B_NEG_BAND_B
    } acc_base_t;

    typedef enum logic [2:0] {
        W_NONE, W_BAND_A, W_LOW_A, W_BAND_B, W_LOW_B
    } wr_sel_t;

    typedef struct packed {
        coef_sel_t coef;
        opnd_sel_t opnd;
        acc_base_t base;
        logic      term_sub;
        wr_sel_t   wr;
        logic      res_wr;
        logic      done;
        logic      jmp_one;
        pc_t       jmp_tgt;
    } ctrl_t;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return {1'b0, {(STATE_BITS-1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        else
            return v[STATE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return v[SAMPLE_BITS-1:0];
    endfunction

    // Program. A multiply's term passes the operand, partial product and term
    // registers to the accumulator; a state write is registered before it is read.
    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t c;
        c = '{coef: C_FREQ, opnd: S_X, base: B_HOLD, term_sub: 1'b0, wr: W_NONE,
              res_wr: 1'b0, done: 1'b0, jmp_one: 1'b0, jmp_tgt: PC_ONE_PASS};
        case (pc)
            // Dispatch on mode.
            6'd0:  c.jmp_one = 1'b1;
            // Two-pass: section A, then section B.
            6'd1:  begin c.coef = C_DAMP_A; c.opnd = S_BAND_A; end
            6'd2:  begin c.coef = C_FREQ;   c.opnd = S_LOW_A;  end
            6'd3:  begin c.coef = C_GAIN_A; c.opnd = S_X;      end
            6'd4:  c.base = B_ZERO;
            6'd5:  c.base = B_ACC;
            6'd6:  begin c.base = B_ACC; c.term_sub = 1'b1; end
            6'd7:  c.wr = W_BAND_A;
            6'd8:  begin c.coef = C_FREQ;   c.opnd = S_BAND_A; end
            6'd9:  begin c.coef = C_DAMP_B; c.opnd = S_BAND_B; end
            6'd10: begin c.coef = C_FREQ;   c.opnd = S_LOW_B;  end
            6'd11:
            begin
                c.coef = C_GAIN_B; c.opnd = S_BAND_A;
                c.base = B_LOW_A;  c.term_sub = 1'b1;
            end
            6'd12: begin c.wr = W_LOW_A; c.base = B_ZERO; end
            6'd13: c.base = B_ACC;
            6'd14: begin c.base = B_ACC; c.term_sub = 1'b1; end
            6'd15: c.wr = W_BAND_B;
            6'd16: begin c.coef = C_FREQ; c.opnd = S_BAND_B; end
            6'd17: begin c.coef = C_MIX;  c.opnd = S_BAND_A; end
            6'd18: ;
            6'd19: begin c.base = B_LOW_B; c.term_sub = 1'b1; end
            6'd20: begin c.wr = W_LOW_B; c.base = B_NEG_BAND_B; end
            6'd21: begin c.res_wr = 1'b1; c.done = 1'b1; end
            // One-pass: section B only.
            6'd22: begin c.coef = C_DAMP_B; c.opnd = S_BAND_B; end
            6'd23: begin c.coef = C_FREQ;   c.opnd = S_LOW_B;  end
            6'd24: begin c.coef = C_GAIN_B; c.opnd = S_X;      end
            6'd25: c.base = B_ZERO;
            6'd26: c.base = B_ACC;
            6'd27: begin c.base = B_ACC; c.term_sub = 1'b1; end
            6'd28: begin c.wr = W_BAND_B; c.res_wr = 1'b1; end
            6'd29: begin c.coef = C_FREQ; c.opnd = S_BAND_B; end
            6'd30: ;
            6'd31: ;
            6'd32: begin c.base = B_LOW_B; c.term_sub = 1'b1; end
            6'd33: begin c.wr = W_LOW_B; c.done = 1'b1; end
            default: c.done = 1'b1;
        endcase
        return c;
    endfunction

endpackage

FILE: design/resonant_two_pole_filter_cascade_unit.sv
// Top level: two-pole resonant filter cascade run by a microcoded sequencer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  in      | in_valid, in_stall, sample_in, clear_state | into block
//  out     | out_valid, out_stall, sample_out           | out of block
//  cfg     | cfg_write, cfg_index, cfg_data             | into block
//
// One beat runs through the two-pass or the one-pass program, from acceptance
// to the result landing in the output register; the step count of the program
// and the pipeline of the shared multiplier set its duration.
// Reset clears all filter state and loads the register defaults.
// A stalled output holds the sequencer on its last step; a new input beat is
// taken once the previous result has moved into the output register.
module resonant_two_pole_filter_cascade_unit
    import rtpf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          clear_state,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [COEF_W-1:0]             cfg_data
);

    // Configuration registers.
    logic                     two_pass_mode_reg;
    logic signed [COEF_W-1:0] freq_coef_reg;
    logic signed [COEF_W-1:0] damp_coef_a_reg;
    logic signed [COEF_W-1:0] gain_coef_a_reg;
    logic signed [COEF_W-1:0] damp_coef_b_reg;
    logic signed [COEF_W-1:0] gain_coef_b_reg;
    logic [MIX_W-1:0]         mix_ratio_a_reg;

    // Sequencer.
    logic  busy_reg;
    logic  busy_next;
    pc_t   pc_reg;
    pc_t   pc_next;
    ctrl_t ctrl;
    logic  hold;
    logic  go;
    logic  in_take;
    logic  out_take;

    // Datapath.
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [STATE_BITS-1:0]  low_a_reg;
    logic signed [STATE_BITS-1:0]  band_a_reg;
    logic signed [STATE_BITS-1:0]  low_b_reg;
    logic signed [STATE_BITS-1:0]  band_b_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       acc_base;
    logic signed [ACC_W-1:0]       term_ext;
    logic signed [STATE_BITS-1:0]  acc_sat;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic signed [SAMPLE_BITS-1:0] res_now;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    // Multiplier pipeline.
    logic signed [COEF_W-1:0]     freq_eff;
    logic signed [CSEL_W-1:0]     c_sel;
    logic signed [STATE_BITS-1:0] s_sel;
    logic [CSEL_W-1:0]            c_abs;
    logic [STATE_BITS-1:0]        s_abs;
    logic [COEF_W-1:0]            mc_reg;
    logic [STATE_BITS-1:0]        ms_reg;
    logic                         neg1_reg;
    logic [PLO_W-1:0]             plo_reg;
    logic [PHI_W-1:0]             phi_reg;
    logic                         neg2_reg;
    logic [PLO_W:0]               plo_rnd;
    logic [QMAG_W-1:0]            q_mag;
    logic signed [TERM_W-1:0]     term_reg;

    assign in_take    = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign in_stall   = busy_reg;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    assign ctrl = ucode(pc_reg);
    assign hold = ctrl.done && out_valid_reg && out_stall;
    assign go   = busy_reg && !hold;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_pass_mode_reg <= 1'b0;
            freq_coef_reg     <= '0;
            damp_coef_a_reg   <= '0;
            gain_coef_a_reg   <= '0;
            damp_coef_b_reg   <= '0;
            gain_coef_b_reg   <= '0;
            mix_ratio_a_reg   <= MIX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TWO_PASS_MODE: two_pass_mode_reg <= cfg_data[0];
                REG_FREQ_COEF:     freq_coef_reg     <= cfg_data;
                REG_DAMP_COEF_A:   damp_coef_a_reg   <= cfg_data;
                REG_GAIN_COEF_A:   gain_coef_a_reg   <= cfg_data;
                REG_DAMP_COEF_B:   damp_coef_b_reg   <= cfg_data;
                REG_GAIN_COEF_B:   gain_coef_b_reg   <= cfg_data;
                REG_MIX_RATIO_A:   mix_ratio_a_reg   <= cfg_data[MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Step counter and busy flag.
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (in_take)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (go)
        begin
            if (ctrl.done)
                busy_next = 1'b0;
            else if (ctrl.jmp_one && !two_pass_mode_reg)
                pc_next = ctrl.jmp_tgt;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        freq_eff = (freq_coef_reg > FREQ_LIMIT) ? FREQ_LIMIT : freq_coef_reg;
        case (ctrl.coef)
            C_FREQ:   c_sel = CSEL_W'(freq_eff);
            C_DAMP_A: c_sel = CSEL_W'(damp_coef_a_reg);
            C_GAIN_A: c_sel = CSEL_W'(gain_coef_a_reg);
            C_DAMP_B: c_sel = CSEL_W'(damp_coef_b_reg);
            C_GAIN_B: c_sel = CSEL_W'(gain_coef_b_reg);
            C_MIX:    c_sel = {{(CSEL_W-MIX_W){1'b0}}, mix_ratio_a_reg};
            default:  c_sel = '0;
        endcase
        case (ctrl.opnd)
            S_X:      s_sel = STATE_BITS'(sample_reg);
            S_BAND_A: s_sel = band_a_reg;
            S_LOW_A:  s_sel = low_a_reg;
            S_BAND_B: s_sel = band_b_reg;
            S_LOW_B:  s_sel = low_b_reg;
            default:  s_sel = '0;
        endcase
        c_abs = c_sel[CSEL_W-1] ? (~c_sel + 1'b1) : c_sel;
        s_abs = s_sel[STATE_BITS-1] ? (~s_sel + 1'b1) : s_sel;
    end

    // The product is formed on magnitudes and rounded half away from zero.
    always_comb
    begin
        plo_rnd = {1'b0, plo_reg} + (PLO_W+1)'(64'd1 << (COEF_FRAC_BITS - 1));
        q_mag   = QMAG_W'(phi_reg) + QMAG_W'(plo_rnd >> COEF_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        mc_reg   <= c_abs[COEF_W-1:0];
        ms_reg   <= s_abs;
        neg1_reg <= c_sel[CSEL_W-1] ^ s_sel[STATE_BITS-1];
        plo_reg  <= PLO_W'(mc_reg * ms_reg[LO_W-1:0]);
        phi_reg  <= PHI_W'(mc_reg * ms_reg[STATE_BITS-1:LO_W]);
        neg2_reg <= neg1_reg;
        term_reg <= neg2_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

    // Accumulator.
    always_comb
    begin
        case (ctrl.base)
            B_ZERO:       acc_base = '0;
            B_ACC:        acc_base = acc_reg;
            B_LOW_A:      acc_base = ACC_W'(low_a_reg);
            B_LOW_B:      acc_base = ACC_W'(low_b_reg);
            B_NEG_BAND_B: acc_base = -ACC_W'(band_b_reg);
            default:      acc_base = acc_reg;
        endcase
        term_ext = ACC_W'(term_reg);
        if (go && ctrl.base != B_HOLD)
            acc_next = ctrl.term_sub ? (acc_base - term_ext) : (acc_base + term_ext);
        else
            acc_next = acc_reg;
        acc_sat = sat_state(acc_reg);
        res_now = sat_sample(acc_reg);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_take)
            sample_reg <= sample_in;
        if (go && ctrl.res_wr)
            res_reg <= res_now;
    end

    // Filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_a_reg  <= '0;
            band_a_reg <= '0;
            low_b_reg  <= '0;
            band_b_reg <= '0;
        end
        else if (in_take && clear_state)
        begin
            low_a_reg  <= '0;
            band_a_reg <= '0;
            low_b_reg  <= '0;
            band_b_reg <= '0;
        end
        else if (go)
        begin
            case (ctrl.wr)
                W_BAND_A: band_a_reg <= acc_sat;
                W_LOW_A:  low_a_reg  <= acc_sat;
                W_BAND_B: band_b_reg <= acc_sat;
                W_LOW_B:  low_b_reg  <= acc_sat;
                default: ;
            endcase
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go && ctrl.done)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (go && ctrl.done)
            sample_out_reg <= ctrl.res_wr ? res_now : res_reg;
    end

endmodule

FILE: design/rtpf_checker.sv
// Port-level checker for the filter cascade, bound to the top level.
module rtpf_checker
    import rtpf_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] sample_out
);

    // A stalled result beat stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("stalled output beat changed");

    // The sequencer is busy right after taking a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while a beat is in work");

    // No result can land the cycle after a beat is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too soon after input beat");

    // The input side frees up on the same edge a result lands.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
    else $error("input still stalled after result landed");

endmodule

bind resonant_two_pole_filter_cascade_unit rtpf_checker u_rtpf_checker (.*);
